### hdl/csfsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfsc_pkg
// Shared constants for the cube shadow face sphere cull block.
// ----------------------------------------------------------------------------
package csfsc_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned CFG_WIDTH = 16;

  localparam logic [CFG_WIDTH-1:0] FACE_CONE_COS_RST = 16'd18919;
  localparam logic [CFG_WIDTH-1:0] FACE_CONE_SIN_RST = 16'd26755;

  typedef enum logic {
    REG_FACE_CONE_COS = 1'b0,
    REG_FACE_CONE_SIN = 1'b1
  } cfg_reg_e;

  localparam logic [5:0] MASK_NONE = 6'd0;
  localparam logic [5:0] MASK_SPOT = 6'd1;
  localparam logic [5:0] MASK_ALL  = 6'd63;

  localparam int unsigned QUO_BITS  = 16;
  localparam int unsigned ROOT2_BITS = 16;

endpackage

### hdl/cube_shadow_face_sphere_cull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_shadow_face_sphere_cull
// Face mask of the cube shadow faces that a bounding sphere can touch.
// ----------------------------------------------------------------------------
// One light/sphere pair is taken every cycle (busy stays low) and its face
// mask appears on face_mask_o with valid_o high for one cycle, after the
// bit-serial pipelines: a square root of the squared distance (one root bit
// per stage), a 16-stage restoring divider for the sphere cone sine and a
// 16-stage root for its cosine. Results cannot be held off; the receiver
// must take each word in the cycle it is shown. Configuration writes take
// effect at once, also for words in flight before the product stage; the
// user must write only once the pipeline has drained, as the block does not.
module cube_shadow_face_sphere_cull #(
  parameter int unsigned COORD_WIDTH = csfsc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       light_x_i,
  input  logic signed [COORD_WIDTH-1:0]       light_y_i,
  input  logic signed [COORD_WIDTH-1:0]       light_z_i,
  input  logic        [COORD_WIDTH-2:0]       light_range_i,
  input  logic                                is_point_i,
  input  logic signed [COORD_WIDTH-1:0]       center_x_i,
  input  logic signed [COORD_WIDTH-1:0]       center_y_i,
  input  logic signed [COORD_WIDTH-1:0]       center_z_i,
  input  logic        [COORD_WIDTH-2:0]       sphere_radius_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic        [csfsc_pkg::CFG_WIDTH-1:0] cfg_wdata_i,
  output logic                                valid_o,
  output logic        [5:0]                   face_mask_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned QW = 2 * W + 2;
  localparam int unsigned KW = 18;
  localparam int unsigned PW = KW + W + 2;

  localparam int unsigned L_SQ   = 1;
  localparam int unsigned L_SUM  = 2;
  localparam int unsigned L_RT1  = 3;
  localparam int unsigned L_DIV  = L_RT1 + W + 1;
  localparam int unsigned L_SS   = L_DIV + csfsc_pkg::QUO_BITS;
  localparam int unsigned L_NEG  = L_SS + 1;
  localparam int unsigned L_RT2  = L_NEG + 1;
  localparam int unsigned L_PROD = L_RT2 + csfsc_pkg::ROOT2_BITS;
  localparam int unsigned L_K    = L_PROD + 1;
  localparam int unsigned L_KD   = L_K + 1;

  typedef struct packed {
    logic                  v;
    logic                  done;
    logic [5:0]            mask;
    logic                  pt;
    logic signed [W:0]     dx;
    logic signed [W:0]     dy;
    logic signed [W:0]     dz;
    logic [W-2:0]          rad;
    logic [W-2:0]          rng;
    logic [QW-1:0]         p0;
    logic [QW-1:0]         p1;
    logic [QW-1:0]         p2;
    logic [QW-1:0]         p3;
    logic [QW-1:0]         p4;
    logic [QW-1:0]         x;
    logic [QW-1:0]         res;
    logic [W:0]            d;
    logic [W+1:0]          rem;
    logic [15:0]           s;
    logic signed [KW-1:0]  k;
    logic signed [PW-1:0]  kd;
  } ctx_t;

  logic [csfsc_pkg::CFG_WIDTH-1:0] cos_q;
  logic [csfsc_pkg::CFG_WIDTH-1:0] sin_q;
  ctx_t pipe_q [0:L_KD];
  ctx_t nx0;
  logic       valid_q;
  logic [5:0] mask_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= csfsc_pkg::FACE_CONE_COS_RST;
      sin_q <= csfsc_pkg::FACE_CONE_SIN_RST;
    end else if (cfg_we_i) begin
      unique case (csfsc_pkg::cfg_reg_e'(cfg_idx_i))
        csfsc_pkg::REG_FACE_CONE_COS: cos_q <= cfg_wdata_i;
        csfsc_pkg::REG_FACE_CONE_SIN: sin_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // entry stage: per-axis offset from light to sphere center
  always_comb begin
    nx0      = '0;
    nx0.v    = start;
    nx0.pt   = is_point_i;
    nx0.rad  = sphere_radius_i;
    nx0.rng  = light_range_i;
    nx0.dx   = {center_x_i[W-1], center_x_i} - {light_x_i[W-1], light_x_i};
    nx0.dy   = {center_y_i[W-1], center_y_i} - {light_y_i[W-1], light_y_i};
    nx0.dz   = {center_z_i[W-1], center_z_i} - {light_z_i[W-1], light_z_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q[0].v <= 1'b0;
    end else begin
      pipe_q[0] <= nx0;
    end
  end

  for (genvar g = 1; g <= L_KD; g++) begin : g_stage
    ctx_t nx;

    if (g == L_SQ) begin : g_sq
      logic [W:0] ax, ay, az;
      logic [W-1:0] reach;
      always_comb begin
        nx    = pipe_q[g-1];
        ax    = pipe_q[g-1].dx[W] ? (W+1)'(-pipe_q[g-1].dx) : pipe_q[g-1].dx;
        ay    = pipe_q[g-1].dy[W] ? (W+1)'(-pipe_q[g-1].dy) : pipe_q[g-1].dy;
        az    = pipe_q[g-1].dz[W] ? (W+1)'(-pipe_q[g-1].dz) : pipe_q[g-1].dz;
        reach = {1'b0, pipe_q[g-1].rad} + {1'b0, pipe_q[g-1].rng};
        nx.p0 = QW'(ax) * QW'(ax);
        nx.p1 = QW'(ay) * QW'(ay);
        nx.p2 = QW'(az) * QW'(az);
        nx.p3 = QW'(reach) * QW'(reach);
        nx.p4 = QW'(pipe_q[g-1].rad) * QW'(pipe_q[g-1].rad);
      end
    end else if (g == L_SUM) begin : g_sum
      always_comb begin
        nx      = pipe_q[g-1];
        nx.x    = pipe_q[g-1].p0 + pipe_q[g-1].p1 + pipe_q[g-1].p2;
        nx.res  = '0;
        nx.done = 1'b1;
        if (nx.x > pipe_q[g-1].p3) begin
          nx.mask = csfsc_pkg::MASK_NONE;
        end else if (!pipe_q[g-1].pt) begin
          nx.mask = csfsc_pkg::MASK_SPOT;
        end else if (nx.x <= pipe_q[g-1].p4) begin
          nx.mask = csfsc_pkg::MASK_ALL;
        end else begin
          nx.done = 1'b0;
          nx.mask = csfsc_pkg::MASK_NONE;
        end
      end
    end else if ((g >= L_RT1 && g < L_DIV) || (g >= L_RT2 && g < L_PROD)) begin : g_root
      // one root bit per stage: subtract the trial square when it fits
      localparam int unsigned SH = (g < L_DIV) ? 2 * (W - (g - L_RT1))
                                               : 2 * (15 - (g - L_RT2));
      logic [QW-1:0] one, t;
      always_comb begin
        nx  = pipe_q[g-1];
        one = QW'(1) << SH;
        t   = pipe_q[g-1].res + one;
        if (pipe_q[g-1].x >= t) begin
          nx.x   = pipe_q[g-1].x - t;
          nx.res = (pipe_q[g-1].res >> 1) + one;
        end else begin
          nx.res = pipe_q[g-1].res >> 1;
        end
      end
    end else if (g >= L_DIV && g < L_SS) begin : g_div
      // restoring divide of radius * 2^15 by d, one quotient bit per stage
      logic [W:0]   dv;
      logic [W+1:0] r;
      always_comb begin
        nx = pipe_q[g-1];
        if (g == L_DIV) begin
          dv = pipe_q[g-1].res[W:0];
          r  = (W+2)'(pipe_q[g-1].rad);
        end else begin
          dv = pipe_q[g-1].d;
          r  = pipe_q[g-1].rem << 1;
        end
        nx.d = dv;
        if (r >= {1'b0, dv}) begin
          nx.rem = r - {1'b0, dv};
          nx.s   = {pipe_q[g-1].s[14:0], 1'b1};
        end else begin
          nx.rem = r;
          nx.s   = {pipe_q[g-1].s[14:0], 1'b0};
        end
      end
    end else if (g == L_SS) begin : g_ss
      always_comb begin
        nx   = pipe_q[g-1];
        nx.x = QW'(pipe_q[g-1].s) * QW'(pipe_q[g-1].s);
      end
    end else if (g == L_NEG) begin : g_neg
      always_comb begin
        nx     = pipe_q[g-1];
        nx.x   = (QW'(1) << 30) - pipe_q[g-1].x;
        nx.res = '0;
      end
    end else if (g == L_PROD) begin : g_prod
      always_comb begin
        nx    = pipe_q[g-1];
        nx.p0 = QW'(cos_q) * QW'(pipe_q[g-1].res[15:0]);
        nx.p1 = QW'(sin_q) * QW'(pipe_q[g-1].s);
      end
    end else if (g == L_K) begin : g_k
      logic signed [32:0] diff;
      always_comb begin
        nx   = pipe_q[g-1];
        diff = $signed({1'b0, pipe_q[g-1].p0[31:0]}) - $signed({1'b0, pipe_q[g-1].p1[31:0]});
        nx.k = KW'(diff >>> 15);
        if (!pipe_q[g-1].done && nx.k <= -$signed(KW'(32768))) begin
          nx.done = 1'b1;
          nx.mask = csfsc_pkg::MASK_ALL;
        end
      end
    end else begin : g_kd
      always_comb begin
        nx    = pipe_q[g-1];
        nx.kd = PW'(pipe_q[g-1].k) * $signed(PW'({1'b0, pipe_q[g-1].d}));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pipe_q[g].v <= 1'b0;
      end else begin
        pipe_q[g] <= nx;
      end
    end
  end

  // face test: +-D * 2^15 >= k * d per face
  logic signed [PW-1:0] lx, ly, lz;
  logic [5:0] faces;
  logic [5:0] mask_d;

  always_comb begin
    lx = PW'(pipe_q[L_KD].dx) <<< 15;
    ly = PW'(pipe_q[L_KD].dy) <<< 15;
    lz = PW'(pipe_q[L_KD].dz) <<< 15;
    faces[0] = lx >= pipe_q[L_KD].kd;
    faces[1] = -lx >= pipe_q[L_KD].kd;
    faces[2] = ly >= pipe_q[L_KD].kd;
    faces[3] = -ly >= pipe_q[L_KD].kd;
    faces[4] = lz >= pipe_q[L_KD].kd;
    faces[5] = -lz >= pipe_q[L_KD].kd;
    if (pipe_q[L_KD].done) begin
      mask_d = pipe_q[L_KD].mask;
    end else if (faces == csfsc_pkg::MASK_NONE) begin
      mask_d = csfsc_pkg::MASK_ALL;
    end else begin
      mask_d = faces;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pipe_q[L_KD].v;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
  end

  assign valid_o     = valid_q;
  assign face_mask_o = mask_q;

endmodule
